/* hw/rtl/ccd_pkg.sv */
// Shared types, constants and helpers for the CUSUM change detector.
package ccd_pkg;

   localparam int CHAN_W      = 8;
   localparam int SAMPLE_W    = 32;
   localparam int FRAC_W      = 16;
   localparam int SUM_W       = 40;
   localparam int CSR_INDEX_W = 2;
   localparam int OUT_DEPTH   = 4;
   localparam int OUT_LEVEL_W = 3;
   localparam int WORK_DEPTH  = 2;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SLACK     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALARM     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTHING = 2'd2;

   localparam logic [FRAC_W-1:0] SLACK_RESET     = 16'd1311;
   localparam logic [FRAC_W-1:0] ALARM_RESET     = 16'd6554;
   localparam logic [FRAC_W-1:0] SMOOTHING_RESET = 16'd655;

   typedef struct packed {
      logic [CHAN_W-1:0]          channel;
      logic signed [SAMPLE_W-1:0] window_average;
   } req_type;

   typedef struct packed {
      logic rise_alarm;
      logic fall_alarm;
      logic first_sample;
   } rsp_type;

   typedef struct packed {
      logic [FRAC_W-1:0] slack_fraction;
      logic [FRAC_W-1:0] alarm_fraction;
      logic [FRAC_W-1:0] smoothing_fraction;
   } cfg_type;

   typedef enum logic [1:0] {
      KIND_SKIP,
      KIND_FIRST,
      KIND_UPDATE
   } kind_type;

   typedef struct packed {
      kind_type                   kind;
      logic [CHAN_W-1:0]          channel;
      logic signed [SAMPLE_W-1:0] window_average;
   } work_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] baseline;
      logic [SUM_W-1:0]           rise_sum;
      logic [SUM_W-1:0]           fall_sum;
   } entry_type;

   // Clamp a grown signed sum into the unsigned accumulator range.
   function automatic logic [SUM_W-1:0] sum_clamp(input logic signed [SUM_W+1:0] t);
      logic [SUM_W-1:0] r;
      if (t < 0) begin
         r = '0;
      end else if (t > $signed({2'b00, SUM_MAX})) begin
         r = SUM_MAX;
      end else begin
         r = t[SUM_W-1:0];
      end
      return r;
   endfunction

endpackage

/* hw/rtl/cusum_change_detector.sv */
// Top level of the per-channel CUSUM change detector.
// A sample passes the front queue, stages A and B and the result queue; rsp_empty then drops.
// No sample issues while the one ahead is in stage A, due to the state read-modify-write;
// two samples queue in front, so req_full rises under a burst or while results back up.
// Reset is synchronous and active high: it clears the started bits, queues and pipeline and
// loads the default fractions; the state memory itself is not cleared.
module cusum_change_detector #(
   parameter int CHANNELS = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  ccd_pkg::req_type                      req_data,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output ccd_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [ccd_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [ccd_pkg::FRAC_W-1:0]            csr_wr_data
);

   ccd_pkg::cfg_type                  cfg_ff;
   logic                              work_valid, work_pop;
   ccd_pkg::work_type                 work;
   logic                              out_push;
   ccd_pkg::rsp_type                  out_data;
   logic [ccd_pkg::OUT_LEVEL_W-1:0]   out_level;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slack_fraction     <= ccd_pkg::SLACK_RESET;
         cfg_ff.alarm_fraction     <= ccd_pkg::ALARM_RESET;
         cfg_ff.smoothing_fraction <= ccd_pkg::SMOOTHING_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ccd_pkg::CSR_SLACK:     cfg_ff.slack_fraction     <= csr_wr_data;
            ccd_pkg::CSR_ALARM:     cfg_ff.alarm_fraction     <= csr_wr_data;
            ccd_pkg::CSR_SMOOTHING: cfg_ff.smoothing_fraction <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   ccd_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .work_valid (work_valid),
      .work_pop   (work_pop),
      .work       (work)
   );

   ccd_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .work_valid (work_valid),
      .work_pop   (work_pop),
      .work       (work),
      .out_level  (out_level),
      .out_push   (out_push),
      .out_data   (out_data)
   );

   ccd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .level     (out_level)
   );

endmodule

/* hw/rtl/ccd_front.sv */
// Front end: accepts samples, classifies them per channel and queues them for the back end.
module ccd_front #(
   parameter int CHANNELS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  ccd_pkg::req_type    req_data,
   output logic                work_valid,
   input  logic                work_pop,
   output ccd_pkg::work_type   work
);

   localparam int DEPTH = (CHANNELS < 256) ? CHANNELS : 256;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DEPTH-1:0]   started_ff;
   ccd_pkg::work_type  queue_ff [ccd_pkg::WORK_DEPTH];
   logic [1:0]         count_ff, count_in;
   logic               wr_ptr_ff, rd_ptr_ff;
   logic               accept, in_range;
   logic [IDX_W-1:0]   idx;
   ccd_pkg::work_type  classified;

   assign req_full   = (count_ff == 2'(ccd_pkg::WORK_DEPTH));
   assign accept     = req_push && !req_full;
   assign in_range   = int'(req_data.channel) < CHANNELS;
   assign idx        = req_data.channel[IDX_W-1:0];
   assign work_valid = (count_ff != 2'd0);
   assign work       = queue_ff[rd_ptr_ff];

   // The started bits are updated in arrival order, so each queued item already
   // knows whether it is the first sample of its channel.
   always_comb begin
      classified.channel        = req_data.channel;
      classified.window_average = req_data.window_average;
      if (!in_range) begin
         classified.kind = ccd_pkg::KIND_SKIP;
      end else if (!started_ff[idx]) begin
         classified.kind = ccd_pkg::KIND_FIRST;
      end else begin
         classified.kind = ccd_pkg::KIND_UPDATE;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (accept && !work_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!accept && work_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= '0;
         count_ff   <= '0;
         wr_ptr_ff  <= 1'b0;
         rd_ptr_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            wr_ptr_ff <= ~wr_ptr_ff;
            if (in_range) begin
               started_ff[idx] <= 1'b1;
            end
         end
         if (work_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

/* hw/rtl/ccd_back.sv */
// Back end: per-channel state memory and the two-stage CUSUM update pipeline.
module ccd_back #(
   parameter int CHANNELS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ccd_pkg::cfg_type                    cfg,
   input  logic                                work_valid,
   output logic                                work_pop,
   input  ccd_pkg::work_type                   work,
   input  logic [ccd_pkg::OUT_LEVEL_W-1:0]     out_level,
   output logic                                out_push,
   output ccd_pkg::rsp_type                    out_data
);

   localparam int DEPTH = (CHANNELS < 256) ? CHANNELS : 256;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW    = ccd_pkg::SAMPLE_W;
   localparam int UW    = ccd_pkg::SUM_W;

   ccd_pkg::entry_type state_mem_ff [DEPTH];

   // Stage A: item plus the entry read for it.
   logic                     a_vld_ff;
   ccd_pkg::kind_type        a_kind_ff;
   logic [IDX_W-1:0]         a_idx_ff;
   logic signed [SW-1:0]     a_avg_ff;
   ccd_pkg::entry_type       rd_ff;

   // Stage B: products and differences ready for the sum update.
   logic                     b_vld_ff;
   ccd_pkg::kind_type        b_kind_ff;
   logic [IDX_W-1:0]         b_idx_ff;
   logic signed [SW-1:0]     b_avg_ff;
   logic signed [SW-1:0]     b_base_ff;
   logic signed [SW:0]       b_diff_ff;
   logic signed [SW-1:0]     b_kb_ff;
   logic signed [SW-1:0]     b_hb_ff;
   logic signed [SW:0]       b_ad_ff;
   logic [UW-1:0]            b_rise_ff;
   logic [UW-1:0]            b_fall_ff;

   logic                     issue;
   logic [IDX_W-1:0]         iss_idx;
   logic signed [SW:0]       a_diff;
   logic signed [48:0]       kb_prod, hb_prod;
   logic signed [49:0]       ad_prod;

   logic signed [UW+1:0]     rise_t, fall_t;
   logic [UW-1:0]            rise_c, fall_c;
   logic                     rise_hit, fall_hit;
   logic                     wr_en;
   ccd_pkg::entry_type       wr_entry;

   // No entry is read while the item ahead is in stage A, so that item has reached its
   // write-back when the next one reads; the bypass covers a repeated channel.
   assign issue    = work_valid && !a_vld_ff &&
                     ({1'b0, out_level} + {{ccd_pkg::OUT_LEVEL_W{1'b0}}, b_vld_ff}
                      < (ccd_pkg::OUT_LEVEL_W+1)'(ccd_pkg::OUT_DEPTH));
   assign work_pop = issue;
   assign iss_idx  = work.channel[IDX_W-1:0];

   always_comb begin
      a_diff  = (SW+1)'(a_avg_ff) - (SW+1)'(rd_ff.baseline);
      kb_prod = $signed({1'b0, cfg.slack_fraction}) * rd_ff.baseline;
      hb_prod = $signed({1'b0, cfg.alarm_fraction}) * rd_ff.baseline;
      ad_prod = $signed({1'b0, cfg.smoothing_fraction}) * a_diff;
   end

   always_comb begin
      rise_t   = $signed({2'b00, b_rise_ff}) + (UW+2)'(b_diff_ff) - (UW+2)'(b_kb_ff);
      fall_t   = $signed({2'b00, b_fall_ff}) - (UW+2)'(b_diff_ff) - (UW+2)'(b_kb_ff);
      rise_c   = ccd_pkg::sum_clamp(rise_t);
      fall_c   = ccd_pkg::sum_clamp(fall_t);
      rise_hit = $signed({2'b00, rise_c}) > (UW+2)'(b_hb_ff);
      fall_hit = $signed({2'b00, fall_c}) > (UW+2)'(b_hb_ff);

      wr_en    = b_vld_ff && (b_kind_ff != ccd_pkg::KIND_SKIP);
      if (b_kind_ff == ccd_pkg::KIND_FIRST) begin
         wr_entry.baseline = b_avg_ff;
         wr_entry.rise_sum = '0;
         wr_entry.fall_sum = '0;
      end else begin
         wr_entry.baseline = b_base_ff + b_ad_ff[SW-1:0];
         wr_entry.rise_sum = rise_hit ? '0 : rise_c;
         wr_entry.fall_sum = fall_hit ? '0 : fall_c;
      end

      out_push              = b_vld_ff;
      out_data.rise_alarm   = (b_kind_ff == ccd_pkg::KIND_UPDATE) && rise_hit;
      out_data.fall_alarm   = (b_kind_ff == ccd_pkg::KIND_UPDATE) && fall_hit;
      out_data.first_sample = (b_kind_ff == ccd_pkg::KIND_FIRST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= issue;
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_mem_ff[b_idx_ff] <= wr_entry;
      end
      if (issue) begin
         rd_ff     <= (wr_en && (b_idx_ff == iss_idx)) ? wr_entry : state_mem_ff[iss_idx];
         a_kind_ff <= work.kind;
         a_idx_ff  <= iss_idx;
         a_avg_ff  <= work.window_average;
      end
      if (a_vld_ff) begin
         b_kind_ff <= a_kind_ff;
         b_idx_ff  <= a_idx_ff;
         b_avg_ff  <= a_avg_ff;
         b_base_ff <= rd_ff.baseline;
         b_diff_ff <= a_diff;
         b_kb_ff   <= kb_prod[47:16];
         b_hb_ff   <= hb_prod[47:16];
         b_ad_ff   <= ad_prod[48:16];
         b_rise_ff <= rd_ff.rise_sum;
         b_fall_ff <= rd_ff.fall_sum;
      end
   end

endmodule

/* hw/rtl/ccd_rsp_fifo.sv */
// Result queue that holds finished alarm results until they are transferred out.
module ccd_rsp_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  ccd_pkg::rsp_type                    push_data,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output ccd_pkg::rsp_type                    rsp_data,
   output logic [ccd_pkg::OUT_LEVEL_W-1:0]     level
);

   localparam int PTR_W = $clog2(ccd_pkg::OUT_DEPTH);

   ccd_pkg::rsp_type                  slot_ff [ccd_pkg::OUT_DEPTH];
   logic [PTR_W-1:0]                  wr_ptr_ff, rd_ptr_ff;
   logic [ccd_pkg::OUT_LEVEL_W-1:0]   level_ff, level_in;
   logic                              pop;

   assign rsp_empty = (level_ff == '0);
   assign pop       = rsp_pop && !rsp_empty;
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign level     = level_ff;

   always_comb begin
      level_in = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (!push && pop) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         level_ff <= level_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/ccd_checker.sv */
// Port-level checks for the CUSUM change detector and their binding to the top level.
module ccd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_push,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input ccd_pkg::rsp_type  rsp_data
);

   // Two queued in front, and the pipeline plus result queue never exceed four.
   localparam logic [3:0] MAX_OUTSTANDING = 4'd6;

   logic [3:0] outstanding_ff, outstanding_in;
   logic       in_xfer, out_xfer;

   assign in_xfer  = req_push && !req_full;
   assign out_xfer = rsp_pop && !rsp_empty;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (in_xfer && !out_xfer) begin
         outstanding_in = outstanding_ff + 4'd1;
      end else if (!in_xfer && out_xfer) begin
         outstanding_in = outstanding_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_no_invented_result: assert property (@(posedge clock) disable iff (reset)
      out_xfer |-> outstanding_ff != 4'd0)
      else $error("result transferred with no sample outstanding");

   a_bounded_outstanding: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= MAX_OUTSTANDING)
      else $error("more samples outstanding than the design can hold");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("waiting result changed or vanished");

   a_first_no_alarm: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.first_sample |-> !rsp_data.rise_alarm && !rsp_data.fall_alarm)
      else $error("first sample reported with an alarm");

endmodule

bind cusum_change_detector ccd_checker u_ccd_checker (.*);
